/* hw/rtl/qslerp_pkg.sv */
package qslerp_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int TRIG_BITS    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQ_STEPS     = 31;
  localparam int DIV_QBITS    = 40;
  localparam int DIV_LAT      = DIV_QBITS + 2;

  localparam int ST_SQ0  = 5;
  localparam int ST_S    = ST_SQ0 + SQ_STEPS;
  localparam int ST_TH   = ST_S + CORDIC_STEPS;
  localparam int ST_MUL  = ST_TH + 1;
  localparam int ST_SIN  = ST_MUL + CORDIC_STEPS;
  localparam int ST_K    = ST_SIN + DIV_LAT;
  localparam int ST_P    = ST_K + 1;
  localparam int OUT_LAT = ST_P + 1;

  localparam longint ONE_F     = longint'(1) << FRAC_BITS;
  localparam longint ONE_D     = longint'(1) << (2 * FRAC_BITS);
  localparam longint EPS       = (ONE_D + 50000) / 100000;
  localparam longint LIN_LIMIT = ONE_D - EPS;
  localparam longint HALF_F    = longint'(1) << (FRAC_BITS - 1);
  localparam longint HALF_T    = longint'(1) << (TRIG_BITS - 1);
  localparam int     C_SHIFT   = TRIG_BITS - 2 * FRAC_BITS;

  localparam logic [31:0] SIN_X0 = 32'h26DD3B6A;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

/* hw/rtl/quaternion_slerp.sv */
// Channel  | Ports                                   | Handshake
// request  | in_first_*, in_second_*, in_weight      | start, taken when busy is low
// result   | out_w/x/y/z, out_used_linear            | out_valid, one cycle, no stall
//
// One request per cycle; busy stays low.
// The delay from request to result is set by the square root,
// the two CORDIC chains and the bit-per-stage divider in series.
// Synchronous reset clears all pipeline valid bits; requests in flight are dropped.
// Results are never held: the pipeline advances every cycle.
module quaternion_slerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_first_w,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_second_w,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  input  logic        [14:0] in_weight,
  output logic               out_valid,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic               out_used_linear
);

  localparam int NST = qslerp_pkg::ST_P;
  localparam int CS  = qslerp_pkg::CORDIC_STEPS;
  localparam int SQ  = qslerp_pkg::SQ_STEPS;
  localparam int FB  = qslerp_pkg::FRAC_BITS;

  typedef struct packed {
    logic             valid;
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [14:0]      t;
    logic             inv;
    logic             lin;
    logic [3:0][15:0] lin_res;
    logic [29:0]      c;
    logic [30:0]      s;
  } pl_t;

  pl_t pl_in;
  pl_t pl_r [1:NST];

  assign busy = 1'b0;

  logic [14:0] wa_in;

  always_comb begin
    pl_in       = '0;
    pl_in.valid = start & ~busy;
    pl_in.a[0]  = in_first_w;
    pl_in.a[1]  = in_first_x;
    pl_in.a[2]  = in_first_y;
    pl_in.a[3]  = in_first_z;
    pl_in.b[0]  = in_second_w;
    pl_in.b[1]  = in_second_x;
    pl_in.b[2]  = in_second_y;
    pl_in.b[3]  = in_second_z;
    pl_in.t     = (in_weight > 15'(qslerp_pkg::ONE_F)) ? 15'(qslerp_pkg::ONE_F) : in_weight;
    wa_in       = 15'(qslerp_pkg::ONE_F) - pl_in.t;
  end

  logic signed [31:0] ab_r [4];
  logic signed [31:0] la_r [4];
  logic signed [31:0] lb_r [4];
  logic signed [33:0] dot_r;
  logic signed [32:0] linp_r [4];
  logic signed [32:0] linm_r [4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ab_r[i] <= $signed(pl_in.a[i]) * $signed(pl_in.b[i]);
      la_r[i] <= $signed(pl_in.a[i]) * $signed({1'b0, wa_in});
      lb_r[i] <= $signed(pl_in.b[i]) * $signed({1'b0, pl_in.t});
    end
    dot_r <= 34'(ab_r[0]) + 34'(ab_r[1]) + 34'(ab_r[2]) + 34'(ab_r[3]);
    for (int i = 0; i < 4; i++) begin
      linp_r[i] <= 33'(la_r[i]) + 33'(lb_r[i]);
      linm_r[i] <= 33'(la_r[i]) - 33'(lb_r[i]);
    end
  end

  logic signed [33:0] adot;
  logic               inv_w;
  logic               lin_w;
  logic [3:0][15:0]   lin_q;
  logic [29:0]        c_w;

  always_comb begin
    logic signed [32:0] lv;
    logic signed [34:0] rv;
    inv_w = dot_r[33];
    adot  = inv_w ? -dot_r : dot_r;
    lin_w = adot > 34'(qslerp_pkg::LIN_LIMIT);
    c_w   = 30'(adot) << qslerp_pkg::C_SHIFT;
    for (int i = 0; i < 4; i++) begin
      lv       = inv_w ? linm_r[i] : linp_r[i];
      rv       = (35'(lv) + 35'(qslerp_pkg::HALF_F)) >>> FB;
      lin_q[i] = qslerp_pkg::sat16(64'(rv));
    end
  end

  logic [59:0] csq_r;
  logic [60:0] sq_n_r   [0:SQ];
  logic [61:0] sq_res_r [0:SQ];

  always_ff @(posedge clk) begin
    csq_r       <= pl_r[3].c * pl_r[3].c;
    sq_n_r[0]   <= (61'(1) << (2 * qslerp_pkg::TRIG_BITS)) - 61'(csq_r);
    sq_res_r[0] <= '0;
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - j));
    logic [61:0] trial;
    logic        take;
    always_comb begin
      trial = sq_res_r[j] + BIT;
      take  = {1'b0, sq_n_r[j]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (take) begin
        sq_n_r[j+1]   <= 61'({1'b0, sq_n_r[j]} - trial);
        sq_res_r[j+1] <= (sq_res_r[j] >> 1) + BIT;
      end else begin
        sq_n_r[j+1]   <= sq_n_r[j];
        sq_res_r[j+1] <= sq_res_r[j] >> 1;
      end
    end
  end

  pl_t pl3_nxt;
  pl_t pls_nxt;

  always_comb begin
    pl3_nxt         = pl_r[2];
    pl3_nxt.inv     = inv_w;
    pl3_nxt.lin     = lin_w;
    pl3_nxt.lin_res = lin_q;
    pl3_nxt.c       = c_w;
    pls_nxt         = pl_r[qslerp_pkg::ST_S];
    pls_nxt.s       = sq_res_r[SQ][30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NST; k++) begin
        pl_r[k].valid <= 1'b0;
      end
    end else begin
      pl_r[1] <= pl_in;
      pl_r[2] <= pl_r[1];
      pl_r[3] <= pl3_nxt;
      for (int k = 4; k <= NST; k++) begin
        if (k == qslerp_pkg::ST_S + 1) begin
          pl_r[k] <= pls_nxt;
        end else begin
          pl_r[k] <= pl_r[k-1];
        end
      end
    end
  end

  logic signed [33:0] cv_x_r [0:CS-1];
  logic signed [33:0] cv_y_r [0:CS-1];
  logic signed [32:0] cv_z_r [0:CS-1];

  for (genvar i = 0; i < CS; i++) begin : g_vec
    logic signed [33:0] xi, yi, dx, dy;
    logic signed [32:0] zi, at;
    if (i == 0) begin : g_first
      assign xi = $signed({4'b0, pl_r[qslerp_pkg::ST_S].c});
      assign yi = $signed({3'b0, sq_res_r[SQ][30:0]});
      assign zi = '0;
    end else begin : g_next
      assign xi = cv_x_r[i-1];
      assign yi = cv_y_r[i-1];
      assign zi = cv_z_r[i-1];
    end
    always_comb begin
      dx = yi >>> i;
      dy = xi >>> i;
      at = $signed({1'b0, qslerp_pkg::ATAN_TAB[i]});
    end
    always_ff @(posedge clk) begin
      if (!yi[33]) begin
        cv_x_r[i] <= xi + dx;
        cv_y_r[i] <= yi - dy;
        cv_z_r[i] <= zi + at;
      end else begin
        cv_x_r[i] <= xi - dx;
        cv_y_r[i] <= yi + dy;
        cv_z_r[i] <= zi - at;
      end
    end
  end

  logic signed [48:0] th_r [2];

  always_ff @(posedge clk) begin
    th_r[0] <= cv_z_r[CS-1] *
               $signed({1'b0, 15'(qslerp_pkg::ONE_F) - pl_r[qslerp_pkg::ST_TH].t});
    th_r[1] <= cv_z_r[CS-1] * $signed({1'b0, pl_r[qslerp_pkg::ST_TH].t});
  end

  logic signed [33:0] sn_x_r [2][0:CS-1];
  logic signed [33:0] sn_y_r [2][0:CS-1];
  logic signed [33:0] sn_z_r [2][0:CS-1];
  logic signed [40:0] k_w [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < CS; i++) begin : g_rot
      logic signed [33:0] xi, yi, zi, dx, dy, at;
      if (i == 0) begin : g_first
        assign xi = 34'(qslerp_pkg::SIN_X0);
        assign yi = '0;
        assign zi = 34'(th_r[l] >>> FB);
      end else begin : g_next
        assign xi = sn_x_r[l][i-1];
        assign yi = sn_y_r[l][i-1];
        assign zi = sn_z_r[l][i-1];
      end
      always_comb begin
        dx = yi >>> i;
        dy = xi >>> i;
        at = $signed({2'b0, qslerp_pkg::ATAN_TAB[i]});
      end
      always_ff @(posedge clk) begin
        if (!zi[33]) begin
          sn_x_r[l][i] <= xi - dx;
          sn_y_r[l][i] <= yi + dy;
          sn_z_r[l][i] <= zi - at;
        end else begin
          sn_x_r[l][i] <= xi + dx;
          sn_y_r[l][i] <= yi - dy;
          sn_z_r[l][i] <= zi + at;
        end
      end
    end

    qslerp_div u_div (
      .clk (clk),
      .num (sn_y_r[l][CS-1]),
      .den (pl_r[qslerp_pkg::ST_SIN].s),
      .quo (k_w[l])
    );
  end

  logic signed [56:0] pa_r [4];
  logic signed [56:0] pb_r [4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pa_r[i] <= $signed(pl_r[qslerp_pkg::ST_K].a[i]) * k_w[0];
      pb_r[i] <= $signed(pl_r[qslerp_pkg::ST_K].b[i]) * k_w[1];
    end
  end

  logic [3:0][15:0] sph;

  always_comb begin
    logic signed [57:0] sum;
    logic signed [58:0] rv;
    for (int i = 0; i < 4; i++) begin
      sum    = pl_r[NST].inv ? 58'(pa_r[i]) - 58'(pb_r[i]) : 58'(pa_r[i]) + 58'(pb_r[i]);
      rv     = (59'(sum) + 59'(qslerp_pkg::HALF_T)) >>> qslerp_pkg::TRIG_BITS;
      sph[i] = qslerp_pkg::sat16(64'(rv));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pl_r[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_w           <= pl_r[NST].lin ? pl_r[NST].lin_res[0] : sph[0];
    out_x           <= pl_r[NST].lin ? pl_r[NST].lin_res[1] : sph[1];
    out_y           <= pl_r[NST].lin ? pl_r[NST].lin_res[2] : sph[2];
    out_z           <= pl_r[NST].lin ? pl_r[NST].lin_res[3] : sph[3];
    out_used_linear <= pl_r[NST].lin;
  end

endmodule

/* hw/rtl/qslerp_div.sv */
module qslerp_div (
  input  logic               clk,
  input  logic signed [33:0] num,
  input  logic        [30:0] den,
  output logic signed [40:0] quo
);

  localparam int QB = qslerp_pkg::DIV_QBITS;

  logic        [30:0]   rem_r [0:QB];
  logic        [QB-1:0] low_r [0:QB];
  logic        [QB-1:0] q_r   [0:QB];
  logic        [30:0]   den_r [0:QB];
  logic                 neg_r [0:QB];
  logic signed [40:0]   quo_r;

  logic signed [33:0] mag;
  logic        [60:0] dvd;

  always_comb begin
    mag = num[33] ? -num : num;
    dvd = 61'(mag[30:0]) << qslerp_pkg::TRIG_BITS;
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= 31'(dvd >> QB);
    low_r[0] <= dvd[QB-1:0];
    q_r[0]   <= '0;
    den_r[0] <= den;
    neg_r[0] <= num[33];
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [31:0] rem2;
    logic        ge;
    always_comb begin
      rem2 = {rem_r[j], low_r[j][QB-1]};
      ge   = rem2 >= {1'b0, den_r[j]};
    end
    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? 31'(rem2 - {1'b0, den_r[j]}) : 31'(rem2);
      low_r[j+1] <= low_r[j] << 1;
      q_r[j+1]   <= {q_r[j][QB-2:0], ge};
      den_r[j+1] <= den_r[j];
      neg_r[j+1] <= neg_r[j];
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[QB] ? -$signed({1'b0, q_r[QB]}) : $signed({1'b0, q_r[QB]});
  end

  assign quo = quo_r;

endmodule

/* hw/rtl/qslerp_chk.sv */
module qslerp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_first_w,
  input logic signed [15:0] in_first_x,
  input logic signed [15:0] in_first_y,
  input logic signed [15:0] in_first_z,
  input logic signed [15:0] in_second_w,
  input logic signed [15:0] in_second_x,
  input logic signed [15:0] in_second_y,
  input logic signed [15:0] in_second_z,
  input logic        [14:0] in_weight,
  input logic               out_valid,
  input logic signed [15:0] out_w,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic               out_used_linear
);

  localparam int LAT = qslerp_pkg::OUT_LAT;

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request produced no result");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_used_linear && $past(in_weight, LAT) == 15'd0)
      |-> (out_w == $past(in_first_w, LAT) && out_z == $past(in_first_z, LAT)))
    else $error("linear blend at zero weight differs from first quaternion");

endmodule

bind quaternion_slerp qslerp_chk u_qslerp_chk (.*);
